[src/btti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btti_pkg
// Shared widths, commands, status codes, register indices and divider request of the bowtie thickness block.
// ----------------------------------------------------------------------------
package btti_pkg;
  localparam int DefTableDepth = 128;
  localparam int CosW = 17;
  localparam int ThkW = 20;
  localparam int DirW = 16;
  localparam int PathW = 24;
  localparam int StatW = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_ABOVE = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_SIZE = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  // serial divider request
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
    logic [6:0]  bits;
  } div_req_t;
endpackage
`default_nettype wire

[src/btti_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btti_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module btti_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire btti_pkg::div_req_t req,
  output logic                   busy,
  output logic                   done,
  output logic [63:0]            quo
);
  import btti_pkg::*;

  logic [63:0] num;
  logic [32:0] rem;
  logic [31:0] den;
  logic [6:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem[31:0], num[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      rem  <= '0;
      den  <= req.den;
      cnt  <= req.bits;
      // left-align the numerator's used bits
      num  <= req.num << (7'd64 - req.bits);
      quo  <= '0;
    end else if (busy) begin
      if (!trial[32]) rem <= trial;
      else rem <= {rem[31:0], num[63]};
      num <= num << 1;
      quo <= {quo[62:0], ~trial[32]};
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[src/btti_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btti_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module btti_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [33:0] val,
  output logic             done,
  output logic [16:0]      root
);
  import btti_pkg::*;

  logic [33:0] v;
  logic [19:0] rem;
  logic [16:0] res;
  logic [4:0]  cnt;
  logic        busy;
  logic [19:0] cur;
  logic [19:0] tr;

  assign cur = {rem[17:0], v[33:32]};
  assign tr  = cur - {1'b0, res, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      v    <= val;
      rem  <= '0;
      res  <= '0;
      cnt  <= 5'd17;
    end else if (busy) begin
      v <= v << 2;
      if (!tr[19]) begin
        rem <= tr;
        res <= {res[15:0], 1'b1};
      end else begin
        rem <= cur;
        res <= {res[15:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign root = res;
endmodule
`default_nettype wire

[src/bowtie_thickness_table_interp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bowtie_thickness_table_interp
// Bowtie filter path length from a cosine/thickness table with interpolation.
// ----------------------------------------------------------------------------
// Write items are taken whenever the block is idle. A query runs the root, the angle
// divide, the range check, then a binary search (one table read per step) or, in
// mode 1, a direct index divide, then the slope divide and the final divide; all
// divisions share the one serial divider and the table has a single read port.
// The next item is taken the cycle after the result is taken.
// Reset (rst, synchronous) clears control and the config registers; table is not cleared.
module bowtie_thickness_table_interp #(
  parameter int TABLE_DEPTH = btti_pkg::DefTableDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cmd[0], entry_index[7:1], entry_cosine[24:8], entry_thickness[44:25],
  // dir_y[60:45], dir_z[76:61], zero fill to 80
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // path_thickness[23:0], status[25:24], zero fill to 32
  output logic [31:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);
  import btti_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0, S_SQRT = 4'd1, S_ADIV = 4'd2,
    S_RD0 = 4'd3, S_RDN = 4'd4, S_SRCH = 4'd5, S_SRW = 4'd6, S_EQ = 4'd7,
    S_RDI = 4'd8, S_RDI1 = 4'd9, S_INT = 4'd10, S_IDIV = 4'd11,
    S_PDIV = 4'd12, S_OUT = 4'd13, S_WAIT = 4'd14;

  logic [3:0] state;
  logic        mode;
  logic [7:0]  tsize;
  logic [16:0] gstep;

  logic [CosW-1:0] cos_mem [TABLE_DEPTH];
  logic [ThkW-1:0] thk_mem [TABLE_DEPTH];
  logic [IW-1:0]   rd_addr;
  logic [CosW-1:0] rd_cos;
  logic [ThkW-1:0] rd_thk;

  logic [15:0] ymag, zmag;
  logic [16:0] r;
  logic [16:0] a;
  logic [CosW-1:0] c0;
  logic [ThkW-1:0] t0, proj;
  logic [IW:0] lo, hi, n;
  logic [1:0]  stat;
  logic        neg;

  div_req_t dreq;
  logic d_busy, d_done;
  logic [63:0] d_quo;
  logic sq_start, sq_done;
  logic [16:0] sq_root;
  logic [33:0] ssum;

  logic [15:0] iy, iz;
  assign iy = s_tdata[60:45];
  assign iz = s_tdata[76:61];

  assign ssum = ({18'd0, ymag} * {18'd0, ymag} + {18'd0, zmag} * {18'd0, zmag}) << 4;

  btti_div u_div (.clk, .rst, .req(dreq), .busy(d_busy), .done(d_done), .quo(d_quo));
  btti_sqrt u_sqrt (.clk, .rst, .start(sq_start), .val(ssum), .done(sq_done),
                    .root(sq_root));

  assign s_tready = (state == S_IDLE);

  // clamp size to 2..depth
  always_comb begin
    if (tsize < 8'd2) n = (IW+1)'(2);
    else if (32'(tsize) > TABLE_DEPTH) n = (IW+1)'(TABLE_DEPTH);
    else n = (IW+1)'(tsize);
  end

  always_ff @(posedge clk) begin
    rd_cos <= cos_mem[rd_addr];
    rd_thk <= thk_mem[rd_addr];
    if (s_tvalid && s_tready && s_tdata[0] == CMD_WRITE &&
        32'(s_tdata[7:1]) < TABLE_DEPTH) begin
      cos_mem[IW'(s_tdata[7:1])] <= s_tdata[24:8];
      thk_mem[IW'(s_tdata[7:1])] <= s_tdata[44:25];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      tsize <= 8'd2;
      gstep <= 17'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode <= cfg_data[0];
        REG_SIZE: tsize <= cfg_data[7:0];
        REG_STEP: gstep <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [IW:0] mid;
  logic [IW:0] eqi;
  logic d_busy_wait, d_run, p_run;
  assign mid = (lo + hi) >> 1;
  assign eqi = d_quo[IW:0];

  always_ff @(posedge clk) begin
    sq_start <= 1'b0;
    dreq.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid && s_tdata[0] == CMD_QUERY) begin
          ymag <= iy[15] ? 16'(17'h10000 - {1'b0, iy}) : iy;
          zmag <= iz[15] ? 16'(17'h10000 - {1'b0, iz}) : iz;
          state <= S_SQRT;
          sq_start <= 1'b1;
        end
        S_SQRT: if (sq_done) begin
          r <= sq_root;
          if (sq_root == 17'd0) begin
            m_tdata <= {6'd0, ST_ZERO, 24'd0};
            m_tvalid <= 1'b1;
            state <= S_WAIT;
          end else begin
            dreq <= '{start: 1'b1, num: {30'd0, zmag, 18'd0},
                      den: {15'd0, sq_root}, bits: 7'd34};
            state <= S_ADIV;
          end
        end
        S_ADIV: if (d_done) begin
          a <= (d_quo > 64'd65536) ? 17'h10000 : d_quo[16:0];
          rd_addr <= '0;
          state <= S_RD0;
        end
        S_RD0: begin
          rd_addr <= IW'(n - 1'b1);
          state <= S_RDN;
        end
        S_RDN: begin
          // rd_cos/rd_thk now hold entry 0
          c0 <= rd_cos;
          t0 <= rd_thk;
          state <= S_SRCH;
        end
        S_SRCH: begin
          // rd holds last entry
          if (a < c0) begin
            proj <= t0; stat <= ST_BELOW; state <= S_PDIV;
          end else if (a >= rd_cos) begin
            proj <= rd_thk; stat <= ST_ABOVE; state <= S_PDIV;
          end else if (mode) begin
            stat <= ST_INTERP;
            dreq <= '{start: 1'b1, num: {47'd0, 17'(a - c0)},
                      den: {15'd0, (gstep == 17'd0) ? 17'd1 : gstep}, bits: 7'd17};
            state <= S_EQ;
          end else begin
            stat <= ST_INTERP;
            lo <= '0;
            hi <= n - 1'b1;
            state <= S_SRW;
            rd_addr <= IW'(((IW+1)'(0) + n - 1'b1) >> 1);
          end
        end
        S_SRW: begin
          if (hi - lo <= 1) begin
            rd_addr <= IW'(lo);
            state <= S_RDI;
          end else begin
            rd_addr <= IW'(mid);
            state <= S_RDI1;
            lo <= lo; // wait for read
          end
        end
        S_RDI1: state <= S_INT; // reuse S_INT as search compare after latency
        S_EQ: if (d_done) begin
          // segment found directly; S_SRW sees hi-lo == 1 and reads it
          if (d_quo > 64'(n - 2'd2)) begin
            lo <= n - 2'd2;
            hi <= n - 2'd1;
          end else begin
            lo <= eqi;
            hi <= eqi + 1'b1;
          end
          state <= S_SRW;
        end
        S_RDI: begin
          rd_addr <= IW'(lo + 1'b1);
          state <= S_IDIV;
          d_busy_wait <= 1'b0;
        end
        S_INT: begin
          if (rd_cos <= a) lo <= mid;
          else hi <= mid;
          state <= S_SRW;
        end
        S_IDIV: begin
          if (!d_busy_wait) begin
            c0 <= rd_cos; t0 <= rd_thk;
            d_busy_wait <= 1'b1;
          end else if (!d_run) begin
            if (rd_cos <= c0 || a <= c0) begin
              proj <= t0; state <= S_PDIV;
            end else if (a >= rd_cos) begin
              proj <= rd_thk; state <= S_PDIV;
            end else begin
              neg <= (rd_thk < t0);
              dreq <= '{start: 1'b1,
                        num: 64'(((rd_thk >= t0) ? 37'(rd_thk - t0) : 37'(t0 - rd_thk))
                                 * 37'(a - c0)),
                        den: {15'd0, 17'(rd_cos - c0)}, bits: 7'd37};
              d_run <= 1'b1;
            end
          end else if (d_done) begin
            proj <= neg ? ThkW'(t0 - d_quo[ThkW-1:0]) : ThkW'(t0 + d_quo[ThkW-1:0]);
            d_run <= 1'b0;
            state <= S_PDIV;
          end
        end
        S_PDIV: if (!d_busy && !dreq.start && !p_run) begin
          dreq <= '{start: 1'b1, num: {28'd0, proj, 16'd0}, den: {15'd0, r}, bits: 7'd36};
          p_run <= 1'b1;
        end else if (d_done) begin
          p_run <= 1'b0;
          m_tdata <= {6'd0, stat, (d_quo > 64'hFFFFFF) ? 24'hFFFFFF : d_quo[23:0]};
          m_tvalid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: if (m_tready) begin
          m_tvalid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE) begin
        d_run <= 1'b0;
        p_run <= 1'b0;
      end
    end
  end

  // a result is only shown once its query is done
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> state == S_WAIT)
    else $error("result valid outside wait");
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("accepting while result pending");
  assert property (@(posedge clk) disable iff (rst) sq_done |-> state == S_SQRT)
    else $error("root done in wrong state");
endmodule
`default_nettype wire
